>>> src/lpg_pkg.sv
// Shared types and constants of the looping playhead generator.
package lpg_pkg;

    localparam int unsigned MAX_FRAMES_DEF = 65536;

    localparam int unsigned FRAME_CNT_W = 17;
    localparam int unsigned SPEED_W     = 16;
    localparam int unsigned MODE_W      = 3;
    localparam int unsigned OPCODE_W    = 3;
    localparam int unsigned HEAD_W      = 16;
    localparam int unsigned FRAC_W      = 10;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 17;

    // Speed limits in Q6.10: 0.01 and 32.0 frames per tick.
    localparam logic [SPEED_W-1:0] SPEED_MIN = 16'd10;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'd32768;

    // The step per tick is at most 32 frames, so a wrap quotient needs six bits.
    localparam int unsigned DIV_SHIFT_MAX = 5;

    localparam logic [OPCODE_W-1:0] OP_TICK        = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PLAY_TOGGLE = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_STOP        = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SEEK        = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SCRUB_BEGIN = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_SCRUB_END   = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SET_PAUSE   = 3'd6;

    localparam logic [MODE_W-1:0] MODE_NONE      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INVERSE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PINGPONG  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ONCE_BACK = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ROUNDTRIP = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_Q10   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_MODE   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STEP,
        ST_MOD,
        ST_FIN,
        ST_EMIT
    } t_state;

endpackage

>>> src/lpg_item_if.sv
// Input channel of the playhead generator: one transport event or tick per transfer.
interface lpg_item_if;
    logic                           valid;
    logic                           ready;
    logic [lpg_pkg::OPCODE_W-1:0]   opcode;
    logic [lpg_pkg::HEAD_W-1:0]     seek_frame;
    logic                           pause_flag;

    modport source (output valid, output opcode, output seek_frame, output pause_flag,
                    input ready);
    modport sink   (input valid, input opcode, input seek_frame, input pause_flag,
                    output ready);
endinterface

>>> src/lpg_result_if.sv
// Result channel of the playhead generator: head position and session flags.
interface lpg_result_if;
    logic                         valid;
    logic                         ready;
    logic [lpg_pkg::HEAD_W-1:0]   frame_index;
    logic                         frame_valid;
    logic                         playing;
    logic                         holding;
    logic                         session_on;
    logic                         natural_end;
    logic                         accepted;

    modport source (output valid, output frame_index, output frame_valid, output playing,
                    output holding, output session_on, output natural_end,
                    output accepted, input ready);
    modport sink   (input valid, input frame_index, input frame_valid, input playing,
                    input holding, input session_on, input natural_end,
                    input accepted, output ready);
endinterface

>>> src/looping_playhead_generator.sv
// Top level: transport sequencer and loop-mode play head for one score slot.
//
// Usage: i_item carries transport events (play toggle, stop, seek, scrub begin and end,
// set pause) and 1 ms ticks; every transfer on i_item yields exactly one transfer on
// o_result with the head position and the session flags after that item. The
// configuration port writes frame_count, speed_q10 and loop_mode, one per cycle with
// i_cfg_we high, while no item is in flight.
//
// Timing: i_item.ready is high only while the sequencer is idle. An event, or a tick
// that does not run the head, passes from the EXEC state to EMIT, which loads o_result
// once the output register is free. A tick that runs the head passes EXEC, STEP and EMIT,
// and, when the head wraps in loop or inverse mode, also MOD and FIN: the wrap position
// comes from a shared compare-and-subtract unit that reduces the overshoot modulo the
// frame count, one quotient bit per cycle, six quotient bits in all. The sequencer goes
// back to idle as it loads the result, and only then takes the next item.
//
// A finished result sits in the output register; the next item may be taken meanwhile,
// and its result waits in the sequencer until the receiver has taken the previous one.
// Reset clears the transport state, the configuration (speed to 1.0 frame per tick)
// and the output valid flag.
module looping_playhead_generator #(
    parameter int unsigned MAX_FRAMES = lpg_pkg::MAX_FRAMES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lpg_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [lpg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    lpg_item_if.sink                          i_item,
    lpg_result_if.source                      o_result
);

    localparam logic [16:0] N_MAX = 17'(MAX_FRAMES);

    function automatic logic [15:0] f_clamp(input logic [15:0] x, input logic [15:0] lim);
        return (x > lim) ? lim : x;
    endfunction

    // Configuration.
    logic [16:0] r_frame_count;
    logic [15:0] r_speed;
    logic [2:0]  r_loop_mode;

    // Sequencer and transport state.
    lpg_pkg::t_state r_state, n_state;
    logic        r_play, n_play;
    logic        r_hold, n_hold;
    logic        r_session, n_session;
    logic        r_backward, n_backward;
    logic [2:0]  r_last_mode, n_last_mode;
    logic [15:0] r_head, n_head;
    logic [9:0]  r_phase, n_phase;
    logic        r_seek_valid, n_seek_valid;
    logic [15:0] r_seek_target, n_seek_target;
    logic        r_resume_valid, n_resume_valid;
    logic [15:0] r_resume_target, n_resume_target;

    // Current item and working values.
    logic [2:0]  r_op, n_op;
    logic [15:0] r_seek_frame, n_seek_frame;
    logic        r_pause_flag, n_pause_flag;
    logic [15:0] r_work_h, n_work_h;
    logic [16:0] r_rem, n_rem;
    logic [2:0]  r_k, n_k;
    logic        r_wrap_fwd, n_wrap_fwd;
    logic        r_f_valid, n_f_valid;
    logic        r_f_ended, n_f_ended;
    logic        r_f_acc, n_f_acc;

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_o_frame_index, n_o_frame_index;
    logic        r_o_frame_valid, n_o_frame_valid;
    logic        r_o_playing, n_o_playing;
    logic        r_o_holding, n_o_holding;
    logic        r_o_session_on, n_o_session_on;
    logic        r_o_natural_end, n_o_natural_end;
    logic        r_o_accepted, n_o_accepted;

    // Shared datapath.
    logic [16:0]        w_n;
    logic               w_n_zero;
    logic [16:0]        w_n_m1_full;
    logic [15:0]        w_nm1;
    logic               w_want;
    logic               w_open_bw;
    logic               w_resume_ok;
    logic [15:0]        w_hb;
    logic               w_bb;
    logic [15:0]        w_h_base;
    logic [15:0]        w_speed_sat;
    logic [15:0]        w_acc;
    logic [5:0]         w_step;
    logic signed [17:0] w_hs;
    logic               w_fwd_edge;
    logic               w_bwd_edge;
    logic [15:0]        w_edge_head;
    logic [17:0]        w_hs_inv;
    logic [16:0]        w_mod_in;
    logic [22:0]        w_div;
    logic               w_rem_ge;

    assign w_n         = (r_frame_count > N_MAX) ? N_MAX : r_frame_count;
    assign w_n_zero    = (w_n == 17'd0);
    assign w_n_m1_full = w_n - 17'd1;
    assign w_nm1       = w_n_m1_full[15:0];
    assign w_want      = r_play || r_hold;

    assign w_open_bw   = (r_loop_mode == lpg_pkg::MODE_INVERSE) ||
                         (r_loop_mode == lpg_pkg::MODE_ONCE_BACK);
    assign w_resume_ok = r_resume_valid && (r_resume_target != 16'd0);

    // Starting head: a new session takes the resume target or the edge it starts from.
    always_comb begin
        if (!r_session) begin
            w_hb = w_resume_ok ? r_resume_target : (w_open_bw ? w_nm1 : 16'd0);
            w_bb = w_open_bw;
        end else begin
            w_hb = r_head;
            w_bb = r_backward;
            if (r_loop_mode != r_last_mode) begin
                if ((r_loop_mode == lpg_pkg::MODE_NONE) ||
                    (r_loop_mode == lpg_pkg::MODE_LOOP)) begin
                    w_bb = 1'b0;
                end else if (w_open_bw) begin
                    w_bb = 1'b1;
                end
            end
        end
    end

    assign w_h_base = r_seek_valid ? f_clamp(r_seek_target, w_nm1) : f_clamp(w_hb, w_nm1);

    assign w_speed_sat = (r_speed < lpg_pkg::SPEED_MIN) ? lpg_pkg::SPEED_MIN :
                         (r_speed > lpg_pkg::SPEED_MAX) ? lpg_pkg::SPEED_MAX : r_speed;
    assign w_acc       = {6'd0, r_phase} + w_speed_sat;
    assign w_step      = w_acc[15:10];
    assign w_hs        = r_backward ? (signed'({2'b00, r_work_h}) - signed'({12'd0, w_step}))
                                    : (signed'({2'b00, r_work_h}) + signed'({12'd0, w_step}));
    assign w_fwd_edge  = !r_backward && (unsigned'(w_hs) >= {1'b0, w_n});
    assign w_bwd_edge  = r_backward && w_hs[17];
    assign w_edge_head = w_fwd_edge ? w_nm1 : 16'd0;

    // Past the backward edge the wrap works on the overshoot minus one, which is ~h.
    assign w_hs_inv = ~unsigned'(w_hs);
    assign w_mod_in = w_fwd_edge ? unsigned'(w_hs[16:0]) : w_hs_inv[16:0];

    assign w_div    = {6'd0, w_n} << r_k;
    assign w_rem_ge = ({6'd0, r_rem} >= w_div);

    assign i_item.ready = (r_state == lpg_pkg::ST_IDLE);

    assign o_result.valid       = r_out_valid;
    assign o_result.frame_index = r_o_frame_index;
    assign o_result.frame_valid = r_o_frame_valid;
    assign o_result.playing     = r_o_playing;
    assign o_result.holding     = r_o_holding;
    assign o_result.session_on  = r_o_session_on;
    assign o_result.natural_end = r_o_natural_end;
    assign o_result.accepted    = r_o_accepted;

    always_comb begin
        n_state         = r_state;
        n_play          = r_play;
        n_hold          = r_hold;
        n_session       = r_session;
        n_backward      = r_backward;
        n_last_mode     = r_last_mode;
        n_head          = r_head;
        n_phase         = r_phase;
        n_seek_valid    = r_seek_valid;
        n_seek_target   = r_seek_target;
        n_resume_valid  = r_resume_valid;
        n_resume_target = r_resume_target;
        n_op            = r_op;
        n_seek_frame    = r_seek_frame;
        n_pause_flag    = r_pause_flag;
        n_work_h        = r_work_h;
        n_rem           = r_rem;
        n_k             = r_k;
        n_wrap_fwd      = r_wrap_fwd;
        n_f_valid       = r_f_valid;
        n_f_ended       = r_f_ended;
        n_f_acc         = r_f_acc;
        n_out_valid     = r_out_valid && !o_result.ready;
        n_o_frame_index = r_o_frame_index;
        n_o_frame_valid = r_o_frame_valid;
        n_o_playing     = r_o_playing;
        n_o_holding     = r_o_holding;
        n_o_session_on  = r_o_session_on;
        n_o_natural_end = r_o_natural_end;
        n_o_accepted    = r_o_accepted;

        unique case (r_state)
            lpg_pkg::ST_IDLE: begin
                if (i_item.valid) begin
                    n_op         = i_item.opcode;
                    n_seek_frame = i_item.seek_frame;
                    n_pause_flag = i_item.pause_flag;
                    n_f_valid    = 1'b0;
                    n_f_ended    = 1'b0;
                    n_f_acc      = 1'b0;
                    n_state      = lpg_pkg::ST_EXEC;
                end
            end

            lpg_pkg::ST_EXEC: begin
                n_state = lpg_pkg::ST_EMIT;
                case (r_op)
                    lpg_pkg::OP_TICK: begin
                        priority if (!r_session && !w_want) begin
                            n_play = r_play;
                        end else if (!r_session && w_n_zero) begin
                            n_play = 1'b0;
                            n_hold = 1'b0;
                        end else if (r_session && !w_want) begin
                            n_session = 1'b0;
                        end else if (w_n_zero) begin
                            // Content went away under an open session.
                            n_play    = 1'b0;
                            n_hold    = 1'b0;
                            n_session = 1'b0;
                            n_f_ended = 1'b1;
                        end else begin
                            if (!r_session) begin
                                n_session      = 1'b1;
                                n_resume_valid = 1'b0;
                            end
                            n_last_mode  = r_loop_mode;
                            n_backward   = w_bb;
                            n_phase      = (!r_session || r_seek_valid) ? 10'd0 : r_phase;
                            n_seek_valid = 1'b0;
                            n_work_h     = w_h_base;
                            n_state      = lpg_pkg::ST_STEP;
                        end
                    end
                    lpg_pkg::OP_PLAY_TOGGLE: begin
                        if (r_play) begin
                            n_play         = 1'b0;
                            n_hold         = 1'b0;
                            n_resume_valid = 1'b0;
                            n_seek_valid   = 1'b0;
                            n_head         = 16'd0;
                            n_f_acc        = 1'b1;
                        end else if (!w_n_zero) begin
                            n_hold  = 1'b0;
                            n_play  = 1'b1;
                            n_f_acc = 1'b1;
                        end
                    end
                    lpg_pkg::OP_STOP: begin
                        n_play         = 1'b0;
                        n_hold         = 1'b0;
                        n_resume_valid = 1'b0;
                        n_seek_valid   = 1'b0;
                        n_head         = 16'd0;
                        n_f_acc        = 1'b1;
                    end
                    lpg_pkg::OP_SEEK: begin
                        if (!w_n_zero) begin
                            n_seek_valid    = 1'b1;
                            n_seek_target   = f_clamp(r_seek_frame, w_nm1);
                            n_resume_valid  = 1'b1;
                            n_resume_target = f_clamp(r_seek_frame, w_nm1);
                            n_head          = f_clamp(r_seek_frame, w_nm1);
                            n_f_acc         = 1'b1;
                        end
                    end
                    lpg_pkg::OP_SCRUB_BEGIN: begin
                        if (!r_play && !w_n_zero) begin
                            n_hold  = 1'b1;
                            n_f_acc = 1'b1;
                        end
                    end
                    lpg_pkg::OP_SCRUB_END: begin
                        n_hold  = 1'b0;
                        n_f_acc = 1'b1;
                    end
                    lpg_pkg::OP_SET_PAUSE: begin
                        if (r_play) begin
                            n_hold  = r_pause_flag;
                            n_f_acc = 1'b1;
                        end
                    end
                    default: begin
                        n_f_acc = 1'b0;
                    end
                endcase
            end

            lpg_pkg::ST_STEP: begin
                n_state = lpg_pkg::ST_EMIT;
                if (r_hold) begin
                    n_head    = r_work_h;
                    n_f_valid = 1'b1;
                end else begin
                    n_phase = w_acc[9:0];
                    if (!w_fwd_edge && !w_bwd_edge) begin
                        n_head    = w_hs[15:0];
                        n_f_valid = 1'b1;
                    end else begin
                        case (r_loop_mode)
                            lpg_pkg::MODE_NONE, lpg_pkg::MODE_ONCE_BACK: begin
                                n_head    = w_edge_head;
                                n_play    = 1'b0;
                                n_hold    = 1'b0;
                                n_session = 1'b0;
                                n_f_ended = 1'b1;
                            end
                            lpg_pkg::MODE_LOOP, lpg_pkg::MODE_INVERSE: begin
                                n_backward = (r_loop_mode == lpg_pkg::MODE_INVERSE);
                                n_phase    = 10'd0;
                                n_rem      = w_mod_in;
                                n_k        = 3'(lpg_pkg::DIV_SHIFT_MAX);
                                n_wrap_fwd = w_fwd_edge;
                                n_state    = lpg_pkg::ST_MOD;
                            end
                            lpg_pkg::MODE_PINGPONG: begin
                                n_backward = !r_backward;
                                n_head     = w_edge_head;
                                n_phase    = 10'd0;
                                n_f_valid  = 1'b1;
                            end
                            lpg_pkg::MODE_ROUNDTRIP: begin
                                if (w_bwd_edge) begin
                                    n_head    = 16'd0;
                                    n_play    = 1'b0;
                                    n_hold    = 1'b0;
                                    n_session = 1'b0;
                                    n_f_ended = 1'b1;
                                end else begin
                                    n_backward = 1'b1;
                                    n_head     = w_nm1;
                                    n_phase    = 10'd0;
                                    n_f_valid  = 1'b1;
                                end
                            end
                            default: begin
                                // Undefined modes saturate at the edge and keep running.
                                n_head    = w_edge_head;
                                n_f_valid = 1'b1;
                            end
                        endcase
                    end
                end
            end

            lpg_pkg::ST_MOD: begin
                // Restoring reduction: one shifted copy of the frame count per cycle.
                if (w_rem_ge) begin
                    n_rem = r_rem - w_div[16:0];
                end
                if (r_k == 3'd0) begin
                    n_state = lpg_pkg::ST_FIN;
                end else begin
                    n_k = r_k - 3'd1;
                end
            end

            lpg_pkg::ST_FIN: begin
                n_head    = r_wrap_fwd ? r_rem[15:0] : (w_nm1 - r_rem[15:0]);
                n_f_valid = 1'b1;
                n_state   = lpg_pkg::ST_EMIT;
            end

            lpg_pkg::ST_EMIT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid     = 1'b1;
                    n_o_frame_index = r_head;
                    n_o_frame_valid = r_f_valid;
                    n_o_playing     = r_play;
                    n_o_holding     = r_hold;
                    n_o_session_on  = r_session;
                    n_o_natural_end = r_f_ended;
                    n_o_accepted    = r_f_acc;
                    n_state         = lpg_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = lpg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= 17'd0;
            r_speed       <= 16'd1024;
            r_loop_mode   <= lpg_pkg::MODE_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lpg_pkg::CFG_FRAME_COUNT: r_frame_count <= i_cfg_data;
                lpg_pkg::CFG_SPEED_Q10:   r_speed       <= i_cfg_data[15:0];
                lpg_pkg::CFG_LOOP_MODE:   r_loop_mode   <= i_cfg_data[2:0];
                default:                  r_loop_mode   <= r_loop_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= lpg_pkg::ST_IDLE;
            r_play         <= 1'b0;
            r_hold         <= 1'b0;
            r_session      <= 1'b0;
            r_backward     <= 1'b0;
            r_last_mode    <= lpg_pkg::MODE_NONE;
            r_head         <= 16'd0;
            r_phase        <= 10'd0;
            r_seek_valid   <= 1'b0;
            r_resume_valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_play         <= n_play;
            r_hold         <= n_hold;
            r_session      <= n_session;
            r_backward     <= n_backward;
            r_last_mode    <= n_last_mode;
            r_head         <= n_head;
            r_phase        <= n_phase;
            r_seek_valid   <= n_seek_valid;
            r_resume_valid <= n_resume_valid;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seek_target   <= n_seek_target;
        r_resume_target <= n_resume_target;
        r_op            <= n_op;
        r_seek_frame    <= n_seek_frame;
        r_pause_flag    <= n_pause_flag;
        r_work_h        <= n_work_h;
        r_rem           <= n_rem;
        r_k             <= n_k;
        r_wrap_fwd      <= n_wrap_fwd;
        r_f_valid       <= n_f_valid;
        r_f_ended       <= n_f_ended;
        r_f_acc         <= n_f_acc;
        r_o_frame_index <= n_o_frame_index;
        r_o_frame_valid <= n_o_frame_valid;
        r_o_playing     <= n_o_playing;
        r_o_holding     <= n_o_holding;
        r_o_session_on  <= n_o_session_on;
        r_o_natural_end <= n_o_natural_end;
        r_o_accepted    <= n_o_accepted;
    end

endmodule

>>> src/lpg_checker.sv
// Port-level assertions of the looping playhead generator and their bind.
module lpg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_frame_index,
    input logic        i_frame_valid,
    input logic        i_playing,
    input logic        i_holding,
    input logic        i_session_on,
    input logic        i_natural_end,
    input logic        i_accepted
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable({i_frame_index, i_frame_valid, i_playing, i_holding,
                     i_session_on, i_natural_end, i_accepted}))
        else $error("result changed while stalled");

    // The sequencer takes one item at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in work");

    // A fetched frame belongs to an open session.
    a_fetch_in_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_valid |-> i_session_on && !i_natural_end)
        else $error("frame fetched outside a session");

    // A run that ended leaves the transport fully released.
    a_end_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_natural_end |-> !i_session_on && !i_playing && !i_holding)
        else $error("run ended with transport still engaged");

    // Events and ticks report through different flags.
    a_event_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_accepted |-> !i_frame_valid && !i_natural_end)
        else $error("event result carries tick flags");

endmodule

bind looping_playhead_generator lpg_checker u_lpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_frame_index (o_result.frame_index),
    .i_frame_valid (o_result.frame_valid),
    .i_playing     (o_result.playing),
    .i_holding     (o_result.holding),
    .i_session_on  (o_result.session_on),
    .i_natural_end (o_result.natural_end),
    .i_accepted    (o_result.accepted)
);

>>> test/testbench.sv
// Testbench of the looping playhead generator: directed and random transport sequences.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RX_HOLD_OFF   = 200;

    localparam logic [lpg_pkg::OPCODE_W-1:0]    OP_UNUSED      = 3'd7;
    localparam logic [lpg_pkg::MODE_W-1:0]      MODE_SATURATE6 = 3'd6;
    localparam logic [lpg_pkg::MODE_W-1:0]      MODE_SATURATE7 = 3'd7;
    localparam logic [lpg_pkg::CFG_INDEX_W-1:0] CFG_UNUSED     = 2'd3;

    typedef struct packed {
        logic [lpg_pkg::OPCODE_W-1:0] opcode;
        logic [lpg_pkg::HEAD_W-1:0]   seek_frame;
        logic                         pause_flag;
    } t_transport_event;

    typedef struct packed {
        logic [lpg_pkg::HEAD_W-1:0] frame_index;
        logic                       frame_valid;
        logic                       playing;
        logic                       holding;
        logic                       session_on;
        logic                       natural_end;
        logic                       accepted;
    } t_playhead_status;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [lpg_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lpg_pkg::CFG_DATA_W-1:0]  cfg_data;

    lpg_item_if   item_if();
    lpg_result_if result_if();

    looping_playhead_generator DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    // Predictor state: configuration registers and transport state.
    logic [lpg_pkg::FRAME_CNT_W-1:0] frames_reg   = '0;
    logic [lpg_pkg::SPEED_W-1:0]     speed_reg    = 16'd1024;
    logic [lpg_pkg::MODE_W-1:0]      mode_reg     = lpg_pkg::MODE_NONE;
    bit                              want_play    = 1'b0;
    bit                              hold_req     = 1'b0;
    bit                              session_live = 1'b0;
    bit                              reverse_dir  = 1'b0;
    logic [lpg_pkg::MODE_W-1:0]      mode_seen    = lpg_pkg::MODE_NONE;
    logic [lpg_pkg::HEAD_W-1:0]      head_pos     = '0;
    logic [lpg_pkg::FRAC_W-1:0]      head_frac    = '0;
    bit                              seek_pending = 1'b0;
    logic [lpg_pkg::HEAD_W-1:0]      seek_pos     = '0;
    bit                              resume_armed = 1'b0;
    logic [lpg_pkg::HEAD_W-1:0]      resume_pos   = '0;

    t_playhead_status expected_status[$];
    int  mismatches        = 0;
    int  hold_off_requests = 0;
    bit  tx_idle_en        = 1'b1;
    bit  rx_idle_en        = 1'b1;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int loaded_frames();
        if (frames_reg > lpg_pkg::MAX_FRAMES_DEF) return int'(lpg_pkg::MAX_FRAMES_DEF);
        return int'(frames_reg);
    endfunction

    function automatic int clamp_frame(int h, int n);
        if (h < 0) return 0;
        if (h > n - 1) return n - 1;
        return h;
    endfunction

    function automatic bit start_session();
        int n;
        n = loaded_frames();
        if (n <= 0) begin
            want_play = 1'b0;
            hold_req  = 1'b0;
            return 1'b0;
        end
        mode_seen   = mode_reg;
        reverse_dir = (mode_reg == lpg_pkg::MODE_INVERSE ||
                       mode_reg == lpg_pkg::MODE_ONCE_BACK);
        head_frac   = '0;
        if (resume_armed && resume_pos > 0)
            head_pos = lpg_pkg::HEAD_W'(clamp_frame(int'(resume_pos), n));
        else
            head_pos = reverse_dir ? lpg_pkg::HEAD_W'(n - 1) : '0;
        resume_armed = 1'b0;
        resume_pos   = '0;
        session_live = 1'b1;
        return 1'b1;
    endfunction

    // Returns 0 when the run ends at an edge.
    function automatic bit move_head();
        int n;
        int h;
        int sp;
        int sum;
        int jump;
        bit alive;
        bit fwd_edge;
        bit bwd_edge;
        n = loaded_frames();
        alive = 1'b1;
        if (n <= 0) return 1'b0;
        if (mode_reg != mode_seen) begin
            mode_seen = mode_reg;
            if (mode_reg == lpg_pkg::MODE_NONE || mode_reg == lpg_pkg::MODE_LOOP)
                reverse_dir = 1'b0;
            else if (mode_reg == lpg_pkg::MODE_INVERSE || mode_reg == lpg_pkg::MODE_ONCE_BACK)
                reverse_dir = 1'b1;
        end
        h = clamp_frame(int'(head_pos), n);
        if (seek_pending) begin
            h = clamp_frame(int'(seek_pos), n);
            head_frac = '0;
            seek_pending = 1'b0;
        end
        if (!hold_req) begin
            sp = int'(speed_reg);
            if (sp < int'(lpg_pkg::SPEED_MIN)) sp = int'(lpg_pkg::SPEED_MIN);
            if (sp > int'(lpg_pkg::SPEED_MAX)) sp = int'(lpg_pkg::SPEED_MAX);
            sum = int'(head_frac) + sp;
            jump = sum >> lpg_pkg::FRAC_W;
            head_frac = sum[lpg_pkg::FRAC_W-1:0];
            if (jump > 0) begin
                h = reverse_dir ? h - jump : h + jump;
                fwd_edge = !reverse_dir && h >= n;
                bwd_edge = reverse_dir && h < 0;
                if (fwd_edge || bwd_edge) begin
                    case (mode_reg)
                        lpg_pkg::MODE_NONE, lpg_pkg::MODE_ONCE_BACK: begin
                            alive = 1'b0;
                        end
                        lpg_pkg::MODE_LOOP: begin
                            reverse_dir = 1'b0;
                            if (h < 0) h = n - 1 - ((-h) - 1) % n;
                            else h = h % n;
                            head_frac = '0;
                        end
                        lpg_pkg::MODE_INVERSE: begin
                            reverse_dir = 1'b1;
                            if (h < 0) h = (n - 1) - ((n - 1) - h) % n;
                            else h = h % n;
                            head_frac = '0;
                        end
                        lpg_pkg::MODE_PINGPONG: begin
                            reverse_dir = !reverse_dir;
                            h = clamp_frame(h, n);
                            head_frac = '0;
                        end
                        lpg_pkg::MODE_ROUNDTRIP: begin
                            if (bwd_edge) begin
                                alive = 1'b0;
                            end else begin
                                reverse_dir = 1'b1;
                                h = clamp_frame(h, n);
                                head_frac = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
        head_pos = lpg_pkg::HEAD_W'(clamp_frame(h, n));
        return alive;
    endfunction

    function automatic void stop_transport();
        want_play    = 1'b0;
        hold_req     = 1'b0;
        resume_armed = 1'b0;
        resume_pos   = '0;
        seek_pending = 1'b0;
        seek_pos     = '0;
        head_pos     = '0;
    endfunction

    function automatic t_playhead_status predict_status(t_transport_event ev);
        t_playhead_status st;
        int n;
        int target;
        bit run;
        n = loaded_frames();
        st = '0;
        case (ev.opcode)
            lpg_pkg::OP_TICK: begin
                run = want_play || hold_req;
                if (!session_live) begin
                    if (run) run = start_session();
                end else if (!run) begin
                    session_live = 1'b0;
                end
                if (run) begin
                    if (move_head()) begin
                        st.frame_valid = 1'b1;
                    end else begin
                        want_play      = 1'b0;
                        hold_req       = 1'b0;
                        session_live   = 1'b0;
                        st.natural_end = 1'b1;
                    end
                end
            end
            lpg_pkg::OP_PLAY_TOGGLE: begin
                if (want_play) begin
                    stop_transport();
                    st.accepted = 1'b1;
                end else if (n > 0) begin
                    hold_req    = 1'b0;
                    want_play   = 1'b1;
                    st.accepted = 1'b1;
                end
            end
            lpg_pkg::OP_STOP: begin
                stop_transport();
                st.accepted = 1'b1;
            end
            lpg_pkg::OP_SEEK: begin
                if (n > 0) begin
                    target       = clamp_frame(int'(ev.seek_frame), n);
                    seek_pending = 1'b1;
                    seek_pos     = lpg_pkg::HEAD_W'(target);
                    resume_armed = 1'b1;
                    resume_pos   = lpg_pkg::HEAD_W'(target);
                    head_pos     = lpg_pkg::HEAD_W'(target);
                    st.accepted  = 1'b1;
                end
            end
            lpg_pkg::OP_SCRUB_BEGIN: begin
                if (!want_play && n > 0) begin
                    hold_req    = 1'b1;
                    st.accepted = 1'b1;
                end
            end
            lpg_pkg::OP_SCRUB_END: begin
                hold_req    = 1'b0;
                st.accepted = 1'b1;
            end
            lpg_pkg::OP_SET_PAUSE: begin
                if (want_play) begin
                    hold_req    = ev.pause_flag;
                    st.accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase
        st.frame_index = head_pos;
        st.playing     = want_play;
        st.holding     = hold_req;
        st.session_on  = session_live;
        return st;
    endfunction

    function automatic void check_field(string name, logic [lpg_pkg::HEAD_W-1:0] want_v,
                                        logic [lpg_pkg::HEAD_W-1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin : result_checker
        t_playhead_status want;
        if (rst_n && result_if.valid && result_if.ready) begin
            if (expected_status.size() == 0) begin
                $error("result transfer with no status expected: frame_index %0d",
                       result_if.frame_index);
                mismatches++;
            end else begin
                want = expected_status.pop_front();
                check_field("frame_index", want.frame_index, result_if.frame_index);
                check_field("frame_valid", lpg_pkg::HEAD_W'(want.frame_valid),
                            lpg_pkg::HEAD_W'(result_if.frame_valid));
                check_field("playing", lpg_pkg::HEAD_W'(want.playing),
                            lpg_pkg::HEAD_W'(result_if.playing));
                check_field("holding", lpg_pkg::HEAD_W'(want.holding),
                            lpg_pkg::HEAD_W'(result_if.holding));
                check_field("session_on", lpg_pkg::HEAD_W'(want.session_on),
                            lpg_pkg::HEAD_W'(result_if.session_on));
                check_field("natural_end", lpg_pkg::HEAD_W'(want.natural_end),
                            lpg_pkg::HEAD_W'(result_if.natural_end));
                check_field("accepted", lpg_pkg::HEAD_W'(want.accepted),
                            lpg_pkg::HEAD_W'(result_if.accepted));
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin : result_receiver
        int hold_left;
        int seen;
        hold_left = 0;
        seen = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_requests != seen) begin
                seen = hold_off_requests;
                hold_left = RX_HOLD_OFF;
            end
            if (hold_left > 0) begin
                result_if.ready = 1'b0;
                hold_left--;
            end else if (rx_idle_en && $urandom_range(99) < 10) begin
                result_if.ready = 1'b0;
            end else begin
                result_if.ready = 1'b1;
            end
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("[looping_playhead_generator] ERROR");
        $finish;
    end

    function automatic t_transport_event transport_event(
            logic [lpg_pkg::OPCODE_W-1:0] op, logic [lpg_pkg::HEAD_W-1:0] frame,
            logic pause);
        t_transport_event ev;
        ev.opcode     = op;
        ev.seek_frame = frame;
        ev.pause_flag = pause;
        return ev;
    endfunction

    function automatic t_transport_event with_random_fields(logic [lpg_pkg::OPCODE_W-1:0] op);
        int r;
        logic [lpg_pkg::HEAD_W-1:0] frame;
        r = $urandom_range(99);
        if (r < 40) frame = lpg_pkg::HEAD_W'($urandom);
        else if (r < 75) frame = lpg_pkg::HEAD_W'($urandom_range(0, 40));
        else frame = lpg_pkg::HEAD_W'(loaded_frames() - 2 + int'($urandom_range(0, 3)));
        return transport_event(op, frame, 1'($urandom_range(1)));
    endfunction

    function automatic t_transport_event random_event();
        int r;
        logic [lpg_pkg::OPCODE_W-1:0] op;
        r = $urandom_range(99);
        if (r < 62) op = lpg_pkg::OP_TICK;
        else if (r < 68) op = lpg_pkg::OP_PLAY_TOGGLE;
        else if (r < 71) op = lpg_pkg::OP_STOP;
        else if (r < 79) op = lpg_pkg::OP_SEEK;
        else if (r < 84) op = lpg_pkg::OP_SCRUB_BEGIN;
        else if (r < 88) op = lpg_pkg::OP_SCRUB_END;
        else if (r < 97) op = lpg_pkg::OP_SET_PAUSE;
        else op = OP_UNUSED;
        return with_random_fields(op);
    endfunction

    function automatic logic [lpg_pkg::CFG_DATA_W-1:0] random_frame_count();
        int r;
        r = $urandom_range(99);
        if (r < 6) return '0;
        if (r < 12) return lpg_pkg::CFG_DATA_W'(1);
        if (r < 60) return lpg_pkg::CFG_DATA_W'($urandom_range(2, 12));
        if (r < 80) return lpg_pkg::CFG_DATA_W'($urandom_range(13, 80));
        if (r < 88) return lpg_pkg::CFG_DATA_W'(lpg_pkg::MAX_FRAMES_DEF);
        if (r < 93) return lpg_pkg::CFG_DATA_W'($urandom_range(60000, 65535));
        return lpg_pkg::CFG_DATA_W'($urandom);
    endfunction

    function automatic logic [lpg_pkg::SPEED_W-1:0] random_speed();
        int r;
        r = $urandom_range(99);
        if (r < 10) return lpg_pkg::SPEED_W'($urandom_range(0, 9));
        if (r < 20) return lpg_pkg::SPEED_W'($urandom_range(32768, 65535));
        if (r < 50) return lpg_pkg::SPEED_W'($urandom_range(10, 1024));
        if (r < 85) return lpg_pkg::SPEED_W'($urandom_range(1024, 8192));
        return lpg_pkg::SPEED_W'($urandom_range(8192, 32768));
    endfunction

    task automatic send_item(input t_transport_event ev);
        @(negedge clk);
        if (tx_idle_en) begin
            while ($urandom_range(99) < 10) begin
                item_if.valid = 1'b0;
                @(negedge clk);
            end
        end
        item_if.valid      = 1'b1;
        item_if.opcode     = ev.opcode;
        item_if.seek_frame = ev.seek_frame;
        item_if.pause_flag = ev.pause_flag;
        @(posedge clk);
        while (item_if.ready !== 1'b1) @(posedge clk);
        expected_status.push_back(predict_status(ev));
    endtask

    task automatic send_op(input logic [lpg_pkg::OPCODE_W-1:0] op);
        send_item(with_random_fields(op));
    endtask

    // Lowers valid and waits until every expected result has arrived.
    task automatic drain_results();
        @(negedge clk);
        item_if.valid = 1'b0;
        while (expected_status.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [lpg_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [lpg_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (index)
            lpg_pkg::CFG_FRAME_COUNT: frames_reg = data;
            lpg_pkg::CFG_SPEED_Q10:   speed_reg  = data[lpg_pkg::SPEED_W-1:0];
            lpg_pkg::CFG_LOOP_MODE:   mode_reg   = data[lpg_pkg::MODE_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic program_random_setup();
        logic [lpg_pkg::MODE_W-1:0] mode;
        if ($urandom_range(9) == 0)
            mode = $urandom_range(1) ? MODE_SATURATE7 : MODE_SATURATE6;
        else
            mode = lpg_pkg::MODE_W'($urandom_range(lpg_pkg::MODE_NONE,
                                                   lpg_pkg::MODE_ROUNDTRIP));
        write_register(lpg_pkg::CFG_FRAME_COUNT, random_frame_count());
        write_register(lpg_pkg::CFG_SPEED_Q10, lpg_pkg::CFG_DATA_W'(random_speed()));
        write_register(lpg_pkg::CFG_LOOP_MODE, lpg_pkg::CFG_DATA_W'(mode));
        if ($urandom_range(7) == 0)
            write_register(CFG_UNUSED, lpg_pkg::CFG_DATA_W'($urandom));
    endtask

    // With no content every request is dropped or refused.
    task automatic test_inactive_transport();
        send_item(transport_event(lpg_pkg::OP_TICK, '0, 1'b0));
        send_item(transport_event(lpg_pkg::OP_PLAY_TOGGLE, '1, 1'b1));
        send_item(transport_event(lpg_pkg::OP_SEEK, '0, 1'b0));
        send_item(transport_event(lpg_pkg::OP_SCRUB_BEGIN, 16'h5A5A, 1'b1));
        send_item(transport_event(lpg_pkg::OP_SET_PAUSE, 16'hA5A5, 1'b1));
        send_item(transport_event(OP_UNUSED, '1, 1'b1));
    endtask

    task automatic test_loop_session();
        drain_results();
        write_register(lpg_pkg::CFG_FRAME_COUNT, lpg_pkg::CFG_DATA_W'(5));
        write_register(lpg_pkg::CFG_SPEED_Q10, lpg_pkg::CFG_DATA_W'(16'hFFFF));
        write_register(lpg_pkg::CFG_LOOP_MODE, lpg_pkg::CFG_DATA_W'(lpg_pkg::MODE_LOOP));
        write_register(CFG_UNUSED, '1);
        send_item(transport_event(lpg_pkg::OP_PLAY_TOGGLE, '0, 1'b0));
        send_item(transport_event(lpg_pkg::OP_TICK, '0, 1'b0));
        send_item(transport_event(lpg_pkg::OP_SEEK, '1, 1'b0));
        send_item(transport_event(lpg_pkg::OP_SCRUB_BEGIN, '0, 1'b0));
        send_item(transport_event(lpg_pkg::OP_SET_PAUSE, '0, 1'b1));
        // The pending seek lands even though the head is held.
        send_item(transport_event(lpg_pkg::OP_TICK, '0, 1'b0));
        send_item(transport_event(lpg_pkg::OP_SET_PAUSE, '0, 1'b0));
        send_item(transport_event(lpg_pkg::OP_TICK, '0, 1'b0));
        send_item(transport_event(lpg_pkg::OP_PLAY_TOGGLE, '0, 1'b0));
        send_item(transport_event(lpg_pkg::OP_TICK, '0, 1'b0));
    endtask

    task automatic test_content_loss();
        drain_results();
        write_register(lpg_pkg::CFG_FRAME_COUNT, lpg_pkg::CFG_DATA_W'(1));
        write_register(lpg_pkg::CFG_SPEED_Q10, '0);
        write_register(lpg_pkg::CFG_LOOP_MODE,
                       lpg_pkg::CFG_DATA_W'(lpg_pkg::MODE_ONCE_BACK));
        send_op(lpg_pkg::OP_PLAY_TOGGLE);
        send_op(lpg_pkg::OP_TICK);
        // Content disappears while the session is open.
        drain_results();
        write_register(lpg_pkg::CFG_FRAME_COUNT, '0);
        send_op(lpg_pkg::OP_TICK);
        // Content disappears after play was requested but before the session opened.
        drain_results();
        write_register(lpg_pkg::CFG_FRAME_COUNT, lpg_pkg::CFG_DATA_W'(3));
        send_op(lpg_pkg::OP_PLAY_TOGGLE);
        drain_results();
        write_register(lpg_pkg::CFG_FRAME_COUNT, '0);
        send_op(lpg_pkg::OP_TICK);
    endtask

    task automatic test_saturated_registers();
        drain_results();
        write_register(lpg_pkg::CFG_FRAME_COUNT, '1);
        write_register(lpg_pkg::CFG_SPEED_Q10, lpg_pkg::CFG_DATA_W'(lpg_pkg::SPEED_MAX));
        write_register(lpg_pkg::CFG_LOOP_MODE, lpg_pkg::CFG_DATA_W'(MODE_SATURATE7));
        send_op(lpg_pkg::OP_SCRUB_BEGIN);
        send_op(lpg_pkg::OP_TICK);
        send_op(lpg_pkg::OP_SCRUB_END);
        send_op(lpg_pkg::OP_STOP);
        send_op(lpg_pkg::OP_TICK);
    endtask

    task automatic test_back_to_back();
        drain_results();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_register(lpg_pkg::CFG_FRAME_COUNT, lpg_pkg::CFG_DATA_W'(7));
        write_register(lpg_pkg::CFG_SPEED_Q10, lpg_pkg::CFG_DATA_W'(1500));
        write_register(lpg_pkg::CFG_LOOP_MODE,
                       lpg_pkg::CFG_DATA_W'(lpg_pkg::MODE_ROUNDTRIP));
        if (!want_play) send_op(lpg_pkg::OP_PLAY_TOGGLE);
        repeat (60) send_item(random_event());
        drain_results();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // The receiver stops for a long stretch while ticks keep coming.
    task automatic test_output_backpressure();
        drain_results();
        write_register(lpg_pkg::CFG_FRAME_COUNT, lpg_pkg::CFG_DATA_W'(9));
        write_register(lpg_pkg::CFG_SPEED_Q10, lpg_pkg::CFG_DATA_W'(700));
        write_register(lpg_pkg::CFG_LOOP_MODE,
                       lpg_pkg::CFG_DATA_W'(lpg_pkg::MODE_PINGPONG));
        tx_idle_en = 1'b0;
        hold_off_requests++;
        if (!want_play) send_op(lpg_pkg::OP_PLAY_TOGGLE);
        repeat (30) send_op(lpg_pkg::OP_TICK);
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_sessions(input int target);
        int sent;
        int burst;
        sent = 0;
        while (sent < target) begin
            drain_results();
            program_random_setup();
            if (!want_play && $urandom_range(3) != 0) begin
                send_op(($urandom_range(3) == 0) ? lpg_pkg::OP_SCRUB_BEGIN
                                                 : lpg_pkg::OP_PLAY_TOGGLE);
                sent++;
            end
            burst = $urandom_range(8, 40);
            repeat (burst) send_item(random_event());
            sent += burst;
        end
    endtask

    initial begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        item_if.valid      = 1'b0;
        item_if.opcode     = lpg_pkg::OP_TICK;
        item_if.seek_frame = '0;
        item_if.pause_flag = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_inactive_transport();
        test_loop_session();
        test_content_loss();
        test_saturated_registers();
        test_back_to_back();
        test_output_backpressure();
        test_random_sessions(330);

        drain_results();
        if (mismatches == 0 && expected_status.size() == 0)
            $display("[looping_playhead_generator] OK");
        else
            $display("[looping_playhead_generator] ERROR");
        $finish;
    end

endmodule
